// ===== sv/ifd_pkg.sv =====
// shared types and constants for the frame deframer
`default_nettype none

package ifd_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 32;

  localparam logic [7:0]  SOH_BYTE      = 8'h01;
  localparam logic [7:0]  STX_BYTE      = 8'h02;
  localparam logic [7:0]  ETX_BYTE      = 8'h03;
  localparam logic [7:0]  SEP_BYTE      = 8'h3B;
  localparam logic [31:0] MIN_FRAME     = 32'd17;
  localparam logic [31:0] PATH_START    = 32'd13;
  localparam logic [31:0] SIZE_OVERHEAD = 32'd3;

  typedef enum logic [2:0] {
    CLS_CONTROL = 3'd0,
    CLS_SENDER  = 3'd1,
    CLS_TARGET  = 3'd2,
    CLS_TERM    = 3'd3,
    CLS_PAYLOAD = 3'd4,
    CLS_TRAILER = 3'd5
  } class_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_SOH    = 3'd2,
    ST_NO_ETX    = 3'd3,
    ST_SIZE      = 3'd4,
    ST_FIELDS    = 3'd5,
    ST_NO_STX    = 3'd6,
    ST_BAD_PATHS = 3'd7
  } status_t;

  typedef struct packed {
    class_t  byte_class;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/ifd_in_if.sv =====
// input byte channel
`default_nettype none

interface ifd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       is_final;

  modport source (output valid, output frame_byte, output is_final, input ready);
  modport sink (input valid, input frame_byte, input is_final, output ready);
endinterface

`default_nettype wire

// ===== sv/ifd_out_if.sv =====
// tagged result channel
`default_nettype none

interface ifd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] byte_class;
  logic       frame_end;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_class, output frame_end,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_class, input frame_end,
                input status, output ready);
endinterface

`default_nettype wire

// ===== sv/ipc_frame_deframer_top.sv =====
// frame deframer top level: input register, parser, result register
// a byte is held in the input register, then its result in the result register, until it is taken
// throughput: one byte per cycle while results are taken, bytes of the same and of the next frame back to back
// the input register keeps taking bytes while a result waits, until both stages are full
// reset: synchronous, clears both valid flags and all frame state
`default_nettype none

module ipc_frame_deframer_top #(
  parameter int unsigned COUNT_WIDTH = ifd_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  ifd_in_if.sink    rx,
  ifd_out_if.source tx
);
  import ifd_pkg::*;

  logic       s_valid;
  logic [7:0] s_byte;
  logic       s_final;
  logic       o_valid;
  logic [7:0] o_byte;
  logic       o_final;
  result_t    o_result;
  result_t    p_result;
  logic       advance;
  logic       step;

  assign advance  = !o_valid || tx.ready;
  assign step     = s_valid && advance;
  assign rx.ready = !s_valid || advance;

  ifd_parser #(
    .CountWidth(COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .frame_byte(s_byte),
    .is_final  (s_final),
    .result    (p_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      s_valid <= 1'b1;
    end else if (advance) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s_byte  <= rx.frame_byte;
      s_final <= rx.is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      o_byte   <= s_byte;
      o_final  <= s_final;
      o_result <= p_result;
    end
  end

  assign tx.valid      = o_valid;
  assign tx.out_byte   = o_byte;
  assign tx.byte_class = o_result.byte_class;
  assign tx.frame_end  = o_final;
  assign tx.status     = o_result.status;

endmodule

`default_nettype wire

// ===== sv/ifd_parser.sv =====
// frame state, byte classification and end-of-frame status
`default_nettype none

module ifd_parser #(
  parameter int unsigned CountWidth = ifd_pkg::COUNT_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      frame_byte,
  input  logic            is_final,
  output ifd_pkg::result_t result
);
  import ifd_pkg::*;

  logic [CountWidth-1:0] byte_index;
  logic [31:0]           total_size;
  logic [31:0]           head_size;
  logic [31:0]           payload_size;
  logic                  start_ok;
  logic                  stx_ok;
  logic [1:0]            separator_count;

  logic [33:0] idx_ext;
  logic [33:0] head_ext;
  logic [33:0] pay_end;
  logic [31:0] stx_pos;
  logic [31:0] size_sum;
  logic [31:0] fsel;
  logic [7:0]  fbyte;
  logic [32:0] frame_len;
  logic [1:0]  lane;
  logic [1:0]  flane;
  logic [1:0]  separator_count_next;
  logic        stx_ok_next;
  logic        is_hdr;
  logic        in_path;
  logic        at_stx;
  logic        is_sep;
  logic        sat;
  logic        stx_good;
  class_t      cls;
  status_t     st;

  always_comb begin
    idx_ext   = 34'(byte_index);
    head_ext  = 34'(head_size);
    pay_end   = head_ext + 34'd2 + 34'(payload_size);
    stx_pos   = head_size + 32'd1;
    size_sum  = head_size + payload_size + SIZE_OVERHEAD;
    frame_len = 33'(byte_index) + 33'd1;
    lane      = byte_index[1:0] - 2'd1;
    flane     = stx_pos[1:0] - 2'd1;
    is_hdr    = idx_ext < 34'(PATH_START);
    in_path   = !is_hdr && (idx_ext < head_ext);
    at_stx    = !is_hdr && (idx_ext == 34'(stx_pos));
    is_sep    = frame_byte == SEP_BYTE;
    sat       = &byte_index;

    stx_ok_next = at_stx ? (frame_byte == STX_BYTE) : stx_ok;
    separator_count_next = separator_count;
    if (in_path && is_sep && separator_count != 2'd3) begin
      separator_count_next = separator_count + 2'd1;
    end

    priority if (is_hdr) begin
      cls = CLS_CONTROL;
    end else if (in_path) begin
      if (separator_count != 2'd0) begin
        cls = CLS_TARGET;
      end else begin
        cls = is_sep ? CLS_TERM : CLS_SENDER;
      end
    end else if (idx_ext == head_ext) begin
      cls = CLS_TERM;
    end else if (idx_ext == head_ext + 34'd1) begin
      cls = CLS_TRAILER;
    end else if (idx_ext < pay_end) begin
      cls = CLS_PAYLOAD;
    end else begin
      cls = CLS_TRAILER;
    end

    priority if (stx_pos <= 32'd4) begin
      fsel = total_size;
    end else if (stx_pos <= 32'd8) begin
      fsel = head_size;
    end else begin
      fsel = payload_size;
    end
    fbyte = 8'(fsel >> {flane, 3'b000});

    priority if (stx_pos == 32'd0) begin
      stx_good = 1'b0;
    end else if (stx_pos < PATH_START) begin
      stx_good = fbyte == STX_BYTE;
    end else begin
      stx_good = stx_ok_next;
    end

    priority if (!is_final) begin
      st = ST_OK;
    end else if (!sat && frame_len < 33'(MIN_FRAME)) begin
      st = ST_SHORT;
    end else if (!start_ok) begin
      st = ST_NO_SOH;
    end else if (frame_byte != ETX_BYTE) begin
      st = ST_NO_ETX;
    end else if (sat || 33'(total_size) != frame_len) begin
      st = ST_SIZE;
    end else if (size_sum != total_size) begin
      st = ST_FIELDS;
    end else if (!stx_good) begin
      st = ST_NO_STX;
    end else if (head_size < PATH_START || separator_count_next != 2'd1) begin
      st = ST_BAD_PATHS;
    end else begin
      st = ST_OK;
    end

    result.byte_class = cls;
    result.status     = st;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_final)) begin
      byte_index      <= '0;
      total_size      <= '0;
      head_size       <= '0;
      payload_size    <= '0;
      start_ok        <= 1'b0;
      stx_ok          <= 1'b0;
      separator_count <= 2'd0;
    end else if (step) begin
      if (!sat) begin
        byte_index <= byte_index + CountWidth'(1);
      end
      if (is_hdr) begin
        priority if (idx_ext == 34'd0) begin
          start_ok <= frame_byte == SOH_BYTE;
        end else if (idx_ext <= 34'd4) begin
          total_size[{lane, 3'b000} +: 8] <= total_size[{lane, 3'b000} +: 8] | frame_byte;
        end else if (idx_ext <= 34'd8) begin
          head_size[{lane, 3'b000} +: 8] <= head_size[{lane, 3'b000} +: 8] | frame_byte;
        end else begin
          payload_size[{lane, 3'b000} +: 8] <= payload_size[{lane, 3'b000} +: 8] | frame_byte;
        end
      end
      stx_ok          <= stx_ok_next;
      separator_count <= separator_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ifd_checker.sv =====
// port-level checks for the frame deframer
`default_nettype none

module ifd_checker (
  input logic       clk,
  input logic       rst,
  input logic       tx_valid,
  input logic       tx_ready,
  input logic [7:0] tx_out_byte,
  input logic [2:0] tx_byte_class,
  input logic       tx_frame_end,
  input logic [2:0] tx_status
);
  import ifd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tx_valid && !tx_ready |=> tx_valid && $stable(tx_out_byte) && $stable(tx_status))
    else $error("result changed while stalled");

  a_status_end: assert property (@(posedge clk) disable iff (rst)
    tx_valid && tx_status != ST_OK |-> tx_frame_end)
    else $error("status reported off the last byte");

  a_class: assert property (@(posedge clk) disable iff (rst)
    tx_valid |-> tx_byte_class <= CLS_TRAILER)
    else $error("byte class out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !tx_valid)
    else $error("result valid after reset");

endmodule

bind ipc_frame_deframer_top ifd_checker u_ifd_checker (
  .clk          (clk),
  .rst          (rst),
  .tx_valid     (tx.valid),
  .tx_ready     (tx.ready),
  .tx_out_byte  (tx.out_byte),
  .tx_byte_class(tx.byte_class),
  .tx_frame_end (tx.frame_end),
  .tx_status    (tx.status)
);

`default_nettype wire

// ===== test/ipc_frame_deframer_top_test.sv =====
// testbench for ipc_frame_deframer_top: directed and random framed byte streams checked against a byte classifier
`timescale 1ns / 100ps

module ipc_frame_deframer_top_test;
  import ifd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_BYTES = 1550;
  localparam int TOTAL_BYTES = 1850;
  localparam longint unsigned POS_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef enum int {
    FK_GOOD,
    FK_NO_SOH,
    FK_NO_ETX,
    FK_BAD_TOTAL,
    FK_BAD_FIELDS,
    FK_NO_STX,
    FK_NO_SEP,
    FK_MANY_SEP,
    FK_SMALL_HEAD,
    FK_WRAP_STX,
    FK_SHORT,
    FK_LENGTH,
    FK_NOISE
  } frame_kind_t;

  typedef struct {
    logic [7:0] data;
    class_t     cls;
    logic       last;
    status_t    st;
  } frame_tag_t;

  logic clk = 1'b0;
  logic rst;

  ifd_in_if  rx_ch ();
  ifd_out_if tx_ch ();

  ipc_frame_deframer_top u_dut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .tx(tx_ch)
  );

  always #10 clk = ~clk;

  // classifier state
  logic [31:0] pos_q = '0;
  logic [31:0] total_q = '0;
  logic [31:0] head_q = '0;
  logic [31:0] pay_q = '0;
  logic        soh_q = 1'b0;
  logic        stx_q = 1'b0;
  logic [1:0]  semi_q = '0;

  frame_tag_t  pending_tags[$];
  logic [7:0]  frame_bytes[$];
  int          good_total, good_head, good_pay;

  bit idle_on = 1'b1;
  int stall_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_seen = 0;
  int status_seen[8];

  function automatic logic [7:0] size_field_byte(input logic [31:0] pos);
    logic [31:0] v;
    if (pos <= 32'd4) v = total_q;
    else if (pos <= 32'd8) v = head_q;
    else v = pay_q;
    return 8'(v >> (((pos - 32'd1) & 32'd3) * 8));
  endfunction

  function automatic frame_tag_t classify_byte(input logic [7:0] b, input logic fin);
    frame_tag_t      t;
    longint unsigned idx, head_l, pay_l, len;
    logic [31:0]     stx_pos;
    logic            stx_good, sat;
    idx = pos_q;
    head_l = head_q;
    pay_l = pay_q;
    stx_pos = head_q + 32'd1;
    t.data = b;
    t.last = fin;
    t.st = ST_OK;
    if (idx < PATH_START) begin
      t.cls = CLS_CONTROL;
      if (idx == 0) soh_q = (b == SOH_BYTE);
      else if (idx <= 4) total_q = total_q | (32'(b) << ((idx - 1) * 8));
      else if (idx <= 8) head_q = head_q | (32'(b) << ((idx - 5) * 8));
      else pay_q = pay_q | (32'(b) << ((idx - 9) * 8));
    end else if (idx < head_l) begin
      if (b == SEP_BYTE) begin
        if (semi_q == 2'd0) t.cls = CLS_TERM;
        else t.cls = CLS_TARGET;
        if (semi_q != 2'd3) semi_q++;
      end else if (semi_q == 2'd0) begin
        t.cls = CLS_SENDER;
      end else begin
        t.cls = CLS_TARGET;
      end
    end else if (idx == head_l) begin
      t.cls = CLS_TERM;
    end else if (idx == head_l + 1) begin
      t.cls = CLS_TRAILER;
    end else if (idx < head_l + 2 + pay_l) begin
      t.cls = CLS_PAYLOAD;
    end else begin
      t.cls = CLS_TRAILER;
    end

    if (idx >= PATH_START && idx == {32'd0, stx_pos}) stx_q = (b == STX_BYTE);

    if (fin) begin
      sat = (idx == POS_MAX);
      len = idx + 1;
      if (stx_pos == 32'd0) stx_good = 1'b0;
      else if (stx_pos < PATH_START) stx_good = (size_field_byte(stx_pos) == STX_BYTE);
      else stx_good = stx_q;

      if (!sat && len < MIN_FRAME) t.st = ST_SHORT;
      else if (!soh_q) t.st = ST_NO_SOH;
      else if (b != ETX_BYTE) t.st = ST_NO_ETX;
      else if (sat || {32'd0, total_q} != len) t.st = ST_SIZE;
      else if (head_q + pay_q + SIZE_OVERHEAD != total_q) t.st = ST_FIELDS;
      else if (!stx_good) t.st = ST_NO_STX;
      else if (head_q < PATH_START || semi_q != 2'd1) t.st = ST_BAD_PATHS;
      else t.st = ST_OK;

      pos_q = '0;
      total_q = '0;
      head_q = '0;
      pay_q = '0;
      soh_q = 1'b0;
      stx_q = 1'b0;
      semi_q = '0;
    end else if (pos_q != 32'hFFFF_FFFF) begin
      pos_q++;
    end
    return t;
  endfunction

  task automatic record_error(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("error: %s", msg);
  endtask

  task automatic check_result();
    frame_tag_t exp;
    results_seen++;
    if (pending_tags.size() == 0) begin
      record_error($sformatf("result %0d arrived with nothing pending (byte %h)",
                             results_seen, tx_ch.out_byte));
      return;
    end
    exp = pending_tags.pop_front();
    if (exp.last) status_seen[exp.st]++;
    if (tx_ch.out_byte !== exp.data || tx_ch.byte_class !== exp.cls ||
        tx_ch.frame_end !== exp.last || tx_ch.status !== exp.st) begin
      record_error($sformatf(
        "result %0d: expected byte %h class %s end %b status %s, got byte %h class %0d end %b status %0d",
        results_seen, exp.data, exp.cls.name(), exp.last, exp.st.name(),
        tx_ch.out_byte, tx_ch.byte_class, tx_ch.frame_end, tx_ch.status));
    end
  endtask

  // result sink, random stalls and watchdog
  always @(posedge clk) begin
    if (!rst && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1) check_result();

    if (stall_left != 0) begin
      stall_left--;
      tx_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      tx_ch.ready <= 1'b0;
    end else begin
      tx_ch.ready <= 1'b1;
    end

    if (rst || (rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
        (tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("no item moved for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, pending_tags.size());
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic fin);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.frame_byte <= b;
    rx_ch.is_final <= fin;
    @(posedge clk);
    while (rx_ch.ready !== 1'b1) @(posedge clk);
    pending_tags.push_back(classify_byte(b, fin));
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    end
    frames_sent++;
  endtask

  function automatic logic [7:0] other_than(input logic [7:0] v);
    logic [7:0] r;
    do r = 8'($urandom); while (r == v);
    return r;
  endfunction

  function automatic logic [7:0] path_char();
    return other_than(SEP_BYTE);
  endfunction

  function automatic int random_payload_len();
    if ($urandom_range(0, 4) == 0) return $urandom_range(13, 60);
    return $urandom_range(0, 12);
  endfunction

  task automatic set_size_fields(input logic [31:0] total, input logic [31:0] head,
                                 input logic [31:0] pay);
    for (int k = 0; k < 4; k++) begin
      frame_bytes[1 + k] = total[8 * k +: 8];
      frame_bytes[5 + k] = head[8 * k +: 8];
      frame_bytes[9 + k] = pay[8 * k +: 8];
    end
  endtask

  task automatic build_good_frame(input int s_len, input int t_len, input int p_len);
    good_head = 14 + s_len + t_len;
    good_pay = p_len;
    good_total = good_head + p_len + 3;
    frame_bytes.delete();
    frame_bytes.push_back(SOH_BYTE);
    repeat (12) frame_bytes.push_back(8'h00);
    set_size_fields(good_total, good_head, good_pay);
    repeat (s_len) frame_bytes.push_back(path_char());
    frame_bytes.push_back(SEP_BYTE);
    repeat (t_len) frame_bytes.push_back(path_char());
    frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(STX_BYTE);
    repeat (p_len) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(ETX_BYTE);
  endtask

  task automatic build_raw_frame(input int len, input logic [31:0] total,
                                 input logic [31:0] head, input logic [31:0] pay);
    frame_bytes.delete();
    frame_bytes.push_back(SOH_BYTE);
    repeat (12) frame_bytes.push_back(8'h00);
    set_size_fields(total, head, pay);
    while (frame_bytes.size() < len - 1) begin
      if ($urandom_range(0, 3) == 0) frame_bytes.push_back(SEP_BYTE);
      else frame_bytes.push_back(8'($urandom));
    end
    frame_bytes.push_back(ETX_BYTE);
  endtask

  task automatic build_random_bytes(input int len);
    frame_bytes.delete();
    repeat (len) frame_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 1) == 0) frame_bytes[0] = SOH_BYTE;
    if ($urandom_range(0, 1) == 0) frame_bytes[len - 1] = ETX_BYTE;
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return FK_GOOD;
    if (r < 42) return FK_NO_SOH;
    if (r < 49) return FK_NO_ETX;
    if (r < 56) return FK_BAD_TOTAL;
    if (r < 63) return FK_BAD_FIELDS;
    if (r < 70) return FK_NO_STX;
    if (r < 76) return FK_NO_SEP;
    if (r < 82) return FK_MANY_SEP;
    if (r < 87) return FK_SMALL_HEAD;
    if (r < 91) return FK_WRAP_STX;
    if (r < 94) return FK_SHORT;
    if (r < 97) return FK_LENGTH;
    return FK_NOISE;
  endfunction

  task automatic build_frame(input frame_kind_t kind);
    int s_len, t_len, h, p, len, n;
    s_len = $urandom_range(0, 6);
    t_len = $urandom_range(0, 6);
    case (kind)
      FK_GOOD: begin
        build_good_frame(s_len, t_len, random_payload_len());
      end
      FK_NO_SOH: begin
        build_good_frame(s_len, t_len, random_payload_len());
        frame_bytes[0] = other_than(SOH_BYTE);
      end
      FK_NO_ETX: begin
        build_good_frame(s_len, t_len, random_payload_len());
        frame_bytes[frame_bytes.size() - 1] = other_than(ETX_BYTE);
      end
      FK_BAD_TOTAL: begin
        build_good_frame(s_len, t_len, random_payload_len());
        set_size_fields(good_total ^ (32'd1 << $urandom_range(0, 31)), good_head, good_pay);
      end
      FK_BAD_FIELDS: begin
        build_good_frame(s_len, t_len, random_payload_len());
        if ($urandom_range(0, 1) == 0) begin
          set_size_fields(good_total, good_head, good_pay ^ (32'd1 << $urandom_range(0, 31)));
        end else begin
          set_size_fields(good_total, good_head ^ (32'd1 << $urandom_range(0, 31)), good_pay);
        end
      end
      FK_NO_STX: begin
        build_good_frame(s_len, t_len, random_payload_len());
        frame_bytes[good_head + 1] = other_than(STX_BYTE);
      end
      FK_NO_SEP: begin
        build_good_frame(s_len, t_len, random_payload_len());
        frame_bytes[13 + s_len] = path_char();
      end
      FK_MANY_SEP: begin
        t_len = $urandom_range(1, 6);
        build_good_frame(s_len, t_len, random_payload_len());
        n = $urandom_range(1, t_len);
        repeat (n) frame_bytes[14 + s_len + $urandom_range(0, t_len - 1)] = SEP_BYTE;
      end
      FK_SMALL_HEAD: begin
        // head size below the path start; stx lookup lands in the size fields, or on byte 13 for a head size of 12
        h = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) begin
          h = 0;
          p = 255;
        end else begin
          p = $urandom_range(14 - h, 24);
        end
        len = h + p + 3;
        build_raw_frame(len, len, h, p);
        if (h == 12 && $urandom_range(0, 1) == 0) frame_bytes[13] = STX_BYTE;
      end
      FK_WRAP_STX: begin
        len = $urandom_range(17, 30);
        build_raw_frame(len, len, 32'hFFFF_FFFF, len - 2);
      end
      FK_SHORT: begin
        build_random_bytes($urandom_range(1, 16));
      end
      FK_LENGTH: begin
        build_good_frame(s_len, t_len, random_payload_len());
        if ($urandom_range(0, 1) == 0) begin
          n = $urandom_range(1, frame_bytes.size() - 2);
          repeat (n) void'(frame_bytes.pop_back());
        end else begin
          repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom));
        end
        frame_bytes[frame_bytes.size() - 1] = ETX_BYTE;
      end
      default: begin
        build_random_bytes($urandom_range(1, 48));
      end
    endcase
  endtask

  task automatic test_directed_frames();
    idle_on = 1'b1;
    build_good_frame(0, 0, 0);
    send_frame();
    frame_bytes = '{8'h00};
    send_frame();
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{SOH_BYTE, 8'hFF, ETX_BYTE};
    send_frame();
  endtask

  task automatic test_random_frames();
    while (bytes_sent < RANDOM_BYTES) begin
      idle_on = ($urandom_range(0, 4) != 0);
      build_frame(pick_kind());
      send_frame();
    end
  endtask

  task automatic test_back_to_back_frames();
    idle_on = 1'b0;
    while (bytes_sent < TOTAL_BYTES) begin
      build_frame(pick_kind());
      send_frame();
    end
  endtask

  initial begin
    string   status_list;
    status_t st_name;
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.frame_byte = 8'h00;
    rx_ch.is_final = 1'b0;
    tx_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed_frames();
    test_random_frames();
    test_back_to_back_frames();

    rx_ch.valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    status_list = "";
    for (int i = 0; i < 8; i++) begin
      st_name = status_t'(i);
      status_list = {status_list, $sformatf(" %s=%0d", st_name.name(), status_seen[i])};
    end
    $display("%0d bytes in %0d frames sent, %0d results checked, %0d bad",
             bytes_sent, frames_sent, results_seen, fail_count);
    $display("frame status mix:%s", status_list);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/ifd_pkg.sv
sv/ifd_in_if.sv
sv/ifd_out_if.sv
sv/ifd_parser.sv
sv/ipc_frame_deframer_top.sv
sv/ifd_checker.sv
test/ipc_frame_deframer_top_test.sv
